// ----- rtl/thermal_frame_average_statistics_assert.svh -----
// Assertion macros used by the thermal frame averaging top level.
`ifndef THERMAL_FRAME_AVERAGE_STATISTICS_ASSERT_SVH
`define THERMAL_FRAME_AVERAGE_STATISTICS_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define TFAS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define TFAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/tfas_pkg.sv -----
// Package with widths, codes and defaults of the thermal frame averaging block.
`default_nettype none
package tfas_pkg;
	localparam int TEMP_W = 16;
	localparam int SUM_W = 20;
	localparam int REQ_W = 3;
	localparam int IDX_W = 10;
	localparam int KIND_W = 2;
	localparam int POS_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam int PIXELS_DEF = 768;
	localparam int COLUMNS_DEF = 32;
	localparam int ROWS_DEF = 24;
	localparam int MAX_SUBFRAMES_DEF = 16;

	localparam logic signed [TEMP_W-1:0] FLOOR_RESET = -16'sd4000;
	localparam logic signed [TEMP_W-1:0] CEILING_RESET = 16'sd30000;

	localparam logic [REQ_W-1:0] REQ_ADD = 3'd0;
	localparam logic [REQ_W-1:0] REQ_END_SUBFRAME = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FINISH = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READBACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NO_FRAME = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'd1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sh7FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 20'sh80000;
endpackage
`default_nettype wire

// ----- rtl/tfas_divider.sv -----
// Iterative rounding divider: num / den rounded half away from zero.
`default_nettype none
module tfas_divider #(
	parameter int NW = 27,
	parameter int DW = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire signed [NW-1:0] num,
	input  wire        [DW-1:0] den,
	output logic                busy,
	output logic                done,
	output logic signed [NW:0]  quo
);
	localparam int QW = NW + 2;
	localparam int RW = DW + 2;
	localparam int CNT_W = $clog2(QW + 1);

	logic [QW-1:0]    n_q;
	logic [DW:0]      d_q;
	logic [RW-2:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NW-1:0]    mag;
	logic [RW-1:0]    shifted;
	logic             fits;
	logic [QW-1:0]    q_signed;

	// Take the magnitude of the dividend
	assign mag = num[NW-1] ? NW'(-num) : NW'(num);
	// One restoring step per cycle
	assign shifted = {rem_q, n_q[QW-1]};
	assign fits = shifted >= RW'(d_q);
	assign q_signed = neg_q ? QW'(-n_q) : n_q;
	assign quo = q_signed[NW:0];

	// Run the division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				neg_q <= num[NW-1];
				n_q <= (QW'(mag) << 1) + QW'(den);
				d_q <= {den, 1'b0};
				rem_q <= '0;
				cnt_q <= CNT_W'(QW);
				busy <= 1'b1;
			end else if (busy) begin
				rem_q <= fits ? (RW-1)'(shifted - RW'(d_q)) : shifted[RW-2:0];
				n_q <= {n_q[QW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/thermal_frame_average_statistics.sv -----
// Top level of the thermal sub-frame averaging and frame statistics block.
//
// Requests enter on start/req_type/pixel_index/pixel_temp and are taken at a
// clock edge with start high and busy low. Results appear for one cycle with
// result_valid high; the receiver must take them, there is no stall.
// Registers temp_floor (index 0) and temp_ceiling (index 1) are written with cfg_we,
// cfg_index and cfg_data; the user must do so while the block is idle (not enforced).
// Sequencing, set by the sum memory and the shared divider:
//   add pixel: read the sum, then saturating write back
//   end subframe, unknown request: handled at acceptance, busy stays low
//   read pixel: memory read at accept, then ST_READ registers the result
//   clear: one sum entry zeroed per cycle until all PIXELS entries are zero
//   finish: each pixel and then each of the four quadrant means and the
//   frame mean runs one pass of the bit-serial divider
//   finish with no sub-frames: ST_NOFRAME registers a no-frame result
// After reset the block sweeps the sum memory to zero with busy high;
// configuration writes are taken during the sweep.
`default_nettype none
`include "thermal_frame_average_statistics_assert.svh"
module thermal_frame_average_statistics #(
	parameter int PIXELS = tfas_pkg::PIXELS_DEF,
	parameter int COLUMNS = tfas_pkg::COLUMNS_DEF,
	parameter int ROWS = tfas_pkg::ROWS_DEF,
	parameter int MAX_SUBFRAMES = tfas_pkg::MAX_SUBFRAMES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [tfas_pkg::REQ_W-1:0]           req_type,
	input  wire  [tfas_pkg::IDX_W-1:0]           pixel_index,
	input  wire  signed [tfas_pkg::TEMP_W-1:0]   pixel_temp,
	input  wire                                  cfg_we,
	input  wire  [tfas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [tfas_pkg::TEMP_W-1:0]          cfg_data,
	output logic                                 result_valid,
	output logic [tfas_pkg::KIND_W-1:0]          result_kind,
	output logic signed [tfas_pkg::TEMP_W-1:0]   pixel_value,
	output logic signed [tfas_pkg::TEMP_W-1:0]   hottest_value,
	output logic [tfas_pkg::POS_W-1:0]           hottest_column,
	output logic [tfas_pkg::POS_W-1:0]           hottest_row,
	output logic signed [tfas_pkg::TEMP_W-1:0]   mean_top_left,
	output logic signed [tfas_pkg::TEMP_W-1:0]   mean_top_right,
	output logic signed [tfas_pkg::TEMP_W-1:0]   mean_bottom_left,
	output logic signed [tfas_pkg::TEMP_W-1:0]   mean_bottom_right,
	output logic signed [tfas_pkg::TEMP_W-1:0]   frame_mean
);
	localparam int TW = tfas_pkg::TEMP_W;
	localparam int SW = tfas_pkg::SUM_W;
	localparam int AW = $clog2(PIXELS);
	localparam int IW = (AW > tfas_pkg::IDX_W ? AW : tfas_pkg::IDX_W) + 1;
	localparam int CW = $clog2(MAX_SUBFRAMES + 1);
	localparam int PCW = $clog2(PIXELS + 1);
	localparam int DW = PCW > CW ? PCW : CW;
	localparam int ACC_RAW = TW + $clog2(PIXELS) + 1;
	localparam int NW = ACC_RAW > SW + 1 ? ACC_RAW : SW + 1;
	localparam int CLW = $clog2(COLUMNS);
	localparam int RWD = $clog2((PIXELS - 1) / COLUMNS + 1) > 0 ?
		$clog2((PIXELS - 1) / COLUMNS + 1) : 1;
	localparam int SEL_FRAME = 4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_ADD, ST_READ, ST_NOFRAME,
		ST_FRD, ST_FDIV, ST_FWAIT, ST_MDIV, ST_MWAIT
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         addr_q;
	logic                  in_range_q;
	logic signed [TW-1:0]  temp_q;
	logic [CW-1:0]         count_q;
	logic signed [TW-1:0]  floor_q;
	logic signed [TW-1:0]  ceiling_q;
	logic [CLW-1:0]        col_q;
	logic [RWD-1:0]        row_q;
	logic signed [TW-1:0]  best_val_q;
	logic [CLW-1:0]        best_col_q;
	logic [RWD-1:0]        best_row_q;
	logic signed [NW-1:0]  total_q;
	logic signed [NW-1:0]  qsum_q [4];
	logic [PCW-1:0]        qcnt_q [4];
	logic signed [TW-1:0]  mean_q [5];
	logic [2:0]            sel_q;

	logic [SW-1:0]         sum_mem [PIXELS];
	logic [TW-1:0]         avg_mem [PIXELS];
	logic signed [SW-1:0]  sum_rd_s1;
	logic signed [TW-1:0]  avg_rd_s1;

	logic                  accept;
	logic [IW-1:0]         idx_w;
	logic [AW-1:0]         idx_addr;
	logic                  idx_ok;
	logic                  sum_re;
	logic [AW-1:0]         sum_raddr;
	logic                  sum_we;
	logic [AW-1:0]         sum_waddr;
	logic [SW-1:0]         sum_wdata;
	logic signed [SW:0]    sum_ext;
	logic signed [SW-1:0]  sum_sat;
	logic                  avg_re;
	logic                  avg_we;

	logic                  div_start;
	logic signed [NW-1:0]  div_num;
	logic [DW-1:0]         div_den;
	logic                  div_busy;
	logic                  div_done;
	logic signed [NW:0]    div_quo;
	logic signed [NW:0]    floor_x;
	logic signed [NW:0]    ceiling_x;
	logic signed [TW-1:0]  pix_v;
	logic [1:0]            quad;
	logic                  last_pixel;

	assign busy = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign idx_w = IW'(pixel_index);
	assign idx_addr = idx_w[AW-1:0];
	assign idx_ok = idx_w < IW'(PIXELS);
	assign last_pixel = ptr_q == AW'(PIXELS - 1);

	// Saturate the pixel sum to the 20-bit signed range
	assign sum_ext = (SW+1)'(sum_rd_s1) + (SW+1)'(temp_q);
	always_comb begin
		sum_ext_sat: begin
			if (sum_ext[SW] != sum_ext[SW-1]) begin
				sum_sat = sum_ext[SW] ? tfas_pkg::SUM_MIN : tfas_pkg::SUM_MAX;
			end else begin
				sum_sat = sum_ext[SW-1:0];
			end
		end
	end

	// Steer the sum memory ports
	assign sum_re = (accept && req_type == tfas_pkg::REQ_ADD && idx_ok) || state_q == ST_FRD;
	assign sum_raddr = state_q == ST_FRD ? ptr_q : idx_addr;
	assign sum_we = state_q == ST_ADD || state_q == ST_CLEAR;
	assign sum_waddr = state_q == ST_CLEAR ? ptr_q : addr_q;
	assign sum_wdata = state_q == ST_CLEAR ? '0 : sum_sat;

	assign avg_re = accept && req_type == tfas_pkg::REQ_READ && idx_ok;
	assign avg_we = state_q == ST_FWAIT && div_done;

	// Pixel sums memory
	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		if (sum_re) begin
			sum_rd_s1 <= sum_mem[sum_raddr];
		end
	end

	// Averaged frame memory
	always_ff @(posedge clk) begin
		if (avg_we) begin
			avg_mem[ptr_q] <= pix_v;
		end
		if (avg_re) begin
			avg_rd_s1 <= avg_mem[idx_addr];
		end
	end

	// Hold the clamp registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= tfas_pkg::FLOOR_RESET;
			ceiling_q <= tfas_pkg::CEILING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfas_pkg::CFG_FLOOR: floor_q <= cfg_data;
				tfas_pkg::CFG_CEILING: ceiling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Feed the divider: pixel sums, then quadrant and frame means
	assign div_start = state_q == ST_FDIV || state_q == ST_MDIV;
	always_comb begin
		if (state_q == ST_FDIV) begin
			div_num = NW'(sum_rd_s1);
			div_den = DW'(count_q);
		end else if (sel_q == 3'(SEL_FRAME)) begin
			div_num = total_q;
			div_den = DW'(PIXELS);
		end else begin
			div_num = qsum_q[sel_q[1:0]];
			div_den = DW'(qcnt_q[sel_q[1:0]]);
		end
	end

	tfas_divider #(.NW(NW), .DW(DW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.done(div_done),
		.quo(div_quo)
	);

	// Clamp the averaged pixel, floor first
	assign floor_x = (NW+1)'(floor_q);
	assign ceiling_x = (NW+1)'(ceiling_q);
	always_comb begin
		if (div_quo < floor_x) begin
			pix_v = floor_q;
		end else if (div_quo > ceiling_x) begin
			pix_v = ceiling_q;
		end else begin
			pix_v = div_quo[TW-1:0];
		end
	end

	assign quad = {32'(row_q) >= ROWS / 2, 32'(col_q) >= COLUMNS / 2};

	// Sequence requests and hold registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q <= '0;
			count_q <= '0;
			sel_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						addr_q <= idx_addr;
						in_range_q <= idx_ok;
						temp_q <= pixel_temp;
						unique case (req_type)
							tfas_pkg::REQ_ADD: begin
								if (idx_ok) state_q <= ST_ADD;
							end
							tfas_pkg::REQ_END_SUBFRAME: begin
								if (count_q != CW'(MAX_SUBFRAMES)) count_q <= count_q + 1'b1;
							end
							tfas_pkg::REQ_FINISH: begin
								ptr_q <= '0;
								col_q <= '0;
								row_q <= '0;
								total_q <= '0;
								for (int k = 0; k < 4; k++) begin
									qsum_q[k] <= '0;
									qcnt_q[k] <= '0;
								end
								state_q <= count_q == '0 ? ST_NOFRAME : ST_FRD;
							end
							tfas_pkg::REQ_READ: state_q <= ST_READ;
							tfas_pkg::REQ_CLEAR: begin
								ptr_q <= '0;
								count_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (last_pixel) state_q <= ST_IDLE;
				end
				ST_ADD: state_q <= ST_IDLE;
				ST_READ: begin
					result_valid <= 1'b1;
					result_kind <= tfas_pkg::KIND_READBACK;
					pixel_value <= in_range_q ? avg_rd_s1 : '0;
					hottest_value <= '0;
					hottest_column <= '0;
					hottest_row <= '0;
					mean_top_left <= '0;
					mean_top_right <= '0;
					mean_bottom_left <= '0;
					mean_bottom_right <= '0;
					frame_mean <= '0;
					state_q <= ST_IDLE;
				end
				ST_NOFRAME: begin
					result_valid <= 1'b1;
					result_kind <= tfas_pkg::KIND_NO_FRAME;
					pixel_value <= '0;
					hottest_value <= '0;
					hottest_column <= '0;
					hottest_row <= '0;
					mean_top_left <= '0;
					mean_top_right <= '0;
					mean_bottom_left <= '0;
					mean_bottom_right <= '0;
					frame_mean <= '0;
					state_q <= ST_IDLE;
				end
				ST_FRD: state_q <= ST_FDIV;
				ST_FDIV: state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (div_done) begin
						// Track hottest pixel, first index wins ties
						if (ptr_q == '0 || pix_v > best_val_q) begin
							best_val_q <= pix_v;
							best_col_q <= col_q;
							best_row_q <= row_q;
						end
						total_q <= total_q + NW'(pix_v);
						qsum_q[quad] <= qsum_q[quad] + NW'(pix_v);
						qcnt_q[quad] <= qcnt_q[quad] + 1'b1;
						ptr_q <= ptr_q + 1'b1;
						if (32'(col_q) == COLUMNS - 1) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (last_pixel) begin
							sel_q <= '0;
							state_q <= ST_MDIV;
						end else begin
							state_q <= ST_FRD;
						end
					end
				end
				ST_MDIV: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (div_done) begin
						mean_q[sel_q] <= div_den == '0 ? '0 : div_quo[TW-1:0];
						if (sel_q == 3'(SEL_FRAME)) begin
							result_valid <= 1'b1;
							result_kind <= tfas_pkg::KIND_SUMMARY;
							pixel_value <= '0;
							hottest_value <= best_val_q;
							hottest_column <= 5'(best_col_q);
							hottest_row <= 5'(best_row_q);
							mean_top_left <= mean_q[0];
							mean_top_right <= mean_q[1];
							mean_bottom_left <= mean_q[2];
							mean_bottom_right <= mean_q[3];
							frame_mean <= div_quo[TW-1:0];
							state_q <= ST_IDLE;
						end else begin
							sel_q <= sel_q + 1'b1;
							state_q <= ST_MDIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TFAS_ASSERT_NOW(a_result_after_work, result_valid, $past(busy))
	`TFAS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_SUBFRAMES))
	`TFAS_ASSERT_NOW(a_div_free, div_start, !div_busy)
	`TFAS_ASSERT_NEXT(a_clear_busy, accept && req_type == tfas_pkg::REQ_CLEAR, busy)
endmodule
`default_nettype wire
